@@ design/speech_gap_and_budget_planner_core_assert.svh @@
// Assertion macros shared by the speech gap and budget planner RTL.
`ifndef SPEECH_GAP_AND_BUDGET_PLANNER_CORE_ASSERT_SVH
`define SPEECH_GAP_AND_BUDGET_PLANNER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SGBP_ASSERT(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define SGBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SGBP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SGBP_ASSERT(label, clk, rst_n, expr, msg)
`define SGBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SGBP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/sgbp_pkg.sv @@
// Types and constants of the speech gap and budget planner.
`default_nettype none
package sgbp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [10:0] PAUSE_CAP_MS  = 11'd1500;
  localparam logic [31:0] MIN_WINDOW_MS = 32'd400;
  localparam logic [12:0] RATE_FLOOR_Q8 = 13'd26;
  localparam logic [23:0] TARGET_MAX    = 24'hFFFFFF;
  localparam logic [25:0] MAXU_MAX      = 26'h3FFFFFF;
  // (prod + 1000 * 2^15) >> 16, then / 1000 as >> 3 and / 125
  localparam logic [25:0] ROUND_BIAS    = 26'd32768000;
  localparam logic [38:0] SAT_LIMIT     = 39'd16777216000;
  localparam logic [31:0] RECIP5        = 32'hCCCCCCCD;   // 2^34 / 5, rounded up
  localparam logic [31:0] RECIP125      = 32'd2199023256; // 2^38 / 125, rounded up

  localparam logic [10:0] THR_RESET   = 11'd300;
  localparam logic [12:0] RATE_RESET  = 13'd3584;
  localparam logic [8:0]  SAFE_RESET  = 9'd230;
  localparam logic [7:0]  LOWER_RESET = 8'd51;
  localparam logic [9:0]  UPPER_RESET = 10'd51;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD,
    CFG_RATE,
    CFG_SAFETY,
    CFG_LOWER_TOL,
    CFG_UPPER_TOL
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_LEAD,
    KIND_INTERNAL,
    KIND_TRAIL,
    KIND_BUDGET
  } kind_e;

  typedef struct packed {
    logic [10:0] threshold;
    logic [12:0] rate;
    logic [8:0]  safety;
    logic [7:0]  lower_tol;
    logic [9:0]  upper_tol;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [32:0] offset;
    logic [10:0]        dur;
    logic [31:0]        slot;
    logic               has_words;
  } entry_t;

endpackage
`default_nettype wire

@@ design/sgbp_in_if.sv @@
// Word item channel.
`default_nettype none
interface sgbp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] segment_start_ms;
  logic [31:0] segment_end_ms;
  logic        has_word;
  logic [31:0] word_start_ms;
  logic [31:0] word_end_ms;
  logic        last_word;

  modport source (
    output valid, segment_start_ms, segment_end_ms, has_word, word_start_ms,
           word_end_ms, last_word,
    input  ready
  );
  modport sink (
    input  valid, segment_start_ms, segment_end_ms, has_word, word_start_ms,
           word_end_ms, last_word,
    output ready
  );
endinterface
`default_nettype wire

@@ design/sgbp_out_if.sv @@
// Result item channel.
`default_nettype none
interface sgbp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [32:0] offset_ms;
  logic [10:0]        duration_ms;
  logic [31:0]        slot_ms;
  logic [31:0]        speech_window_ms;
  logic [23:0]        target_units;
  logic [23:0]        min_units;
  logic [25:0]        max_units;
  logic               has_words;
  logic               last_result;

  modport source (
    output valid, result_kind, offset_ms, duration_ms, slot_ms, speech_window_ms,
           target_units, min_units, max_units, has_words, last_result,
    input  ready
  );
  modport sink (
    input  valid, result_kind, offset_ms, duration_ms, slot_ms, speech_window_ms,
           target_units, min_units, max_units, has_words, last_result,
    output ready
  );
endinterface
`default_nettype wire

@@ design/sgbp_queue.sv @@
// Short queue of classified entries between front and back.
`default_nettype none
`include "speech_gap_and_budget_planner_core_assert.svh"
module sgbp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sgbp_pkg::entry_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output sgbp_pkg::entry_t      head_o,
  output logic                  empty_o
);

  sgbp_pkg::entry_t                 mem_q [sgbp_pkg::QUEUE_DEPTH];
  logic [sgbp_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [sgbp_pkg::QPTR_W:0]        count_q;

  assign full_o  = (count_q == (sgbp_pkg::QPTR_W+1)'(sgbp_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `SGBP_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o), "push into full queue")
  `SGBP_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && empty_o), "pop from empty queue")
  `SGBP_ASSERT_NXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "queue count did not rise")

endmodule
`default_nettype wire

@@ design/sgbp_front.sv @@
// Front end: takes word items, tracks segment state, queues pauses and budget requests.
`default_nettype none
module sgbp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  sgbp_in_if.sink             items_i,
  input  wire sgbp_pkg::cfg_t cfg_i,
  output logic                push_o,
  output sgbp_pkg::entry_t    push_data_o,
  input  wire logic           full_i
);

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_WORD,
    FS_TRAIL,
    FS_BUDGET
  } fstate_e;

  fstate_e     state_q;
  logic [31:0] seg_start_q, seg_end_q, ws_q, we_q;
  logic        has_word_q, last_q;
  logic [31:0] prev_end_q;
  logic        have_prev_q, saw_word_q;

  logic [32:0]        lead_diff, gap_diff, sel_diff, trail_diff, slot_diff;
  logic signed [32:0] prev_off;
  logic [31:0]        word_len, trail_len, thr32, slot;
  logic               word_valid, word_hit, trail_hit, advance;

  function automatic logic [10:0] cap_len(input logic [31:0] len);
    cap_len = (len > 32'(sgbp_pkg::PAUSE_CAP_MS)) ? sgbp_pkg::PAUSE_CAP_MS : len[10:0];
  endfunction

  assign items_i.ready = (state_q == FS_IDLE);

  always_comb begin
    thr32      = {21'b0, cfg_i.threshold};
    word_valid = has_word_q && (we_q > ws_q);
    lead_diff  = {1'b0, ws_q} - {1'b0, seg_start_q};
    gap_diff   = {1'b0, ws_q} - {1'b0, prev_end_q};
    sel_diff   = have_prev_q ? gap_diff : lead_diff;
    word_len   = sel_diff[32] ? '0 : sel_diff[31:0];
    // a negative internal gap is an overlap, never a pause
    word_hit   = word_valid && !(have_prev_q && sel_diff[32]) && (word_len >= thr32);
    prev_off   = signed'({1'b0, prev_end_q} - {1'b0, seg_start_q});
    trail_diff = {1'b0, seg_end_q} - {1'b0, prev_end_q};
    trail_len  = trail_diff[32] ? '0 : trail_diff[31:0];
    trail_hit  = have_prev_q && (trail_len >= thr32);
    slot_diff  = {1'b0, seg_end_q} - {1'b0, seg_start_q};
    slot       = (slot_diff[32] || (slot_diff[31:0] == '0)) ? 32'd1 : slot_diff[31:0];
  end

  always_comb begin
    push_o                = 1'b0;
    advance               = 1'b0;
    push_data_o.kind      = sgbp_pkg::KIND_LEAD;
    push_data_o.offset    = '0;
    push_data_o.dur       = '0;
    push_data_o.slot      = '0;
    push_data_o.has_words = 1'b0;
    case (state_q)
      FS_WORD: begin
        push_o             = word_hit && !full_i;
        advance            = !word_hit || !full_i;
        push_data_o.kind   = have_prev_q ? sgbp_pkg::KIND_INTERNAL : sgbp_pkg::KIND_LEAD;
        push_data_o.offset = have_prev_q ? prev_off : '0;
        push_data_o.dur    = cap_len(word_len);
      end
      FS_TRAIL: begin
        push_o             = trail_hit && !full_i;
        advance            = !trail_hit || !full_i;
        push_data_o.kind   = sgbp_pkg::KIND_TRAIL;
        push_data_o.offset = prev_off;
        push_data_o.dur    = cap_len(trail_len);
      end
      FS_BUDGET: begin
        push_o                = !full_i;
        advance               = !full_i;
        push_data_o.kind      = sgbp_pkg::KIND_BUDGET;
        push_data_o.slot      = slot;
        push_data_o.has_words = saw_word_q;
      end
      default: begin
        push_o  = 1'b0;
        advance = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (items_i.valid && items_i.ready) begin
      seg_start_q <= items_i.segment_start_ms;
      seg_end_q   <= items_i.segment_end_ms;
      has_word_q  <= items_i.has_word;
      ws_q        <= items_i.word_start_ms;
      we_q        <= items_i.word_end_ms;
      last_q      <= items_i.last_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      prev_end_q  <= '0;
      have_prev_q <= 1'b0;
      saw_word_q  <= 1'b0;
    end else begin
      case (state_q)
        FS_IDLE: begin
          if (items_i.valid) begin
            state_q <= FS_WORD;
          end
        end
        FS_WORD: begin
          if (advance) begin
            if (has_word_q) begin
              saw_word_q <= 1'b1;
            end
            if (word_valid) begin
              have_prev_q <= 1'b1;
              if (!have_prev_q || (we_q > prev_end_q)) begin
                prev_end_q <= we_q;
              end
            end
            state_q <= last_q ? FS_TRAIL : FS_IDLE;
          end
        end
        FS_TRAIL: begin
          if (advance) begin
            state_q <= FS_BUDGET;
          end
        end
        FS_BUDGET: begin
          if (advance) begin
            prev_end_q  <= '0;
            have_prev_q <= 1'b0;
            saw_word_q  <= 1'b0;
            state_q     <= FS_IDLE;
          end
        end
        default: begin
          state_q <= FS_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/sgbp_back.sv @@
// Back end: delivers pauses, sums pause time, computes the segment budget.
`default_nettype none
`include "speech_gap_and_budget_planner_core_assert.svh"
module sgbp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sgbp_pkg::cfg_t   cfg_i,
  input  wire sgbp_pkg::entry_t head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  sgbp_out_if.source            results_o
);

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_DIV5,
    BS_CUT,
    BS_MIN,
    BS_WIN,
    BS_PROD,
    BS_RND,
    BS_DIV,
    BS_TOL,
    BS_OUT
  } bstate_e;

  bstate_e     state_q;
  logic [31:0] ptot_q;
  logic [31:0] slot_q;
  logic        hw_q;
  logic [29:0] q5_q;
  logic [21:0] rsf_q;
  logic [30:0] cut40_q;
  logic [31:0] cut_q, win_q;
  logic [53:0] prod_q;
  logic [30:0] x_q;
  logic        sat_q;
  logic [23:0] target_q, ld_q;
  logic [25:0] ud_q;

  logic                  ov_q;
  sgbp_pkg::kind_e       o_kind_q;
  logic signed [32:0]    o_off_q;
  logic [10:0]           o_dur_q;
  logic [31:0]           o_slot_q, o_win_q;
  logic [23:0]           o_tgt_q, o_min_q;
  logic [25:0]           o_max_q;
  logic                  o_hw_q, o_last_q;

  logic        out_free;
  logic [32:0] psum;
  logic [31:0] ptot_d;
  logic [12:0] rate_eff;
  logic [21:0] rsf_d;
  logic [63:0] prod5;
  logic [31:0] times5, rem;
  logic [30:0] cut40_d;
  logic [31:0] cut_d, diffw, win_d;
  logic [54:0] rsum;
  logic [38:0] p2;
  logic [62:0] qprod;
  logic [23:0] qv, target_d;
  logic [32:0] ldp;
  logic [34:0] udp;
  logic [23:0] minu;
  logic [26:0] maxs;
  logic [25:0] maxu;

  assign out_free = !ov_q || results_o.ready;
  assign pop_o    = (state_q == BS_IDLE) && !empty_i &&
                    ((head_i.kind == sgbp_pkg::KIND_BUDGET) || out_free);

  always_comb begin
    psum     = 33'(ptot_q) + 33'(head_i.dur);
    ptot_d   = psum[32] ? '1 : psum[31:0];
    rate_eff = (cfg_i.rate < sgbp_pkg::RATE_FLOOR_Q8) ? sgbp_pkg::RATE_FLOOR_Q8 : cfg_i.rate;
    rsf_d    = 22'(rate_eff) * 22'(cfg_i.safety);
    prod5    = 64'(slot_q) * 64'(sgbp_pkg::RECIP5);
    // slot * 40 / 100 = 2 * (slot / 5) + (2 * rem >= 5)
    times5   = {q5_q, 2'b00} + {2'b00, q5_q};
    rem      = slot_q - times5;
    cut40_d  = {q5_q, 1'b0} + 31'(rem >= 32'd3);
    cut_d    = (ptot_q < {1'b0, cut40_q}) ? ptot_q : {1'b0, cut40_q};
    diffw    = slot_q - cut_q;
    win_d    = (diffw < sgbp_pkg::MIN_WINDOW_MS) ? sgbp_pkg::MIN_WINDOW_MS : diffw;
    rsum     = 55'(prod_q) + 55'(sgbp_pkg::ROUND_BIAS);
    p2       = rsum[54:16];
    qprod    = 63'(x_q) * 63'(sgbp_pkg::RECIP125);
    qv       = qprod[61:38];
    target_d = sat_q ? sgbp_pkg::TARGET_MAX : ((qv == '0) ? 24'd1 : qv);
    ldp      = 33'(target_q) * 33'(cfg_i.lower_tol) + 33'd128;
    udp      = 35'(target_q) * 35'(cfg_i.upper_tol) + 35'd128;
    minu     = (ld_q >= target_q) ? 24'd1 : target_q - ld_q;
    maxs     = 27'(target_q) + 27'(ud_q);
    maxu     = (maxs > 27'(sgbp_pkg::MAXU_MAX)) ? sgbp_pkg::MAXU_MAX : maxs[25:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BS_IDLE;
      ptot_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (ov_q && results_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        BS_IDLE: begin
          if (pop_o) begin
            if (head_i.kind == sgbp_pkg::KIND_BUDGET) begin
              slot_q  <= head_i.slot;
              hw_q    <= head_i.has_words;
              state_q <= BS_DIV5;
            end else begin
              ov_q     <= 1'b1;
              o_kind_q <= head_i.kind;
              o_off_q  <= head_i.offset;
              o_dur_q  <= head_i.dur;
              o_slot_q <= '0;
              o_win_q  <= '0;
              o_tgt_q  <= '0;
              o_min_q  <= '0;
              o_max_q  <= '0;
              o_hw_q   <= 1'b0;
              o_last_q <= 1'b0;
              ptot_q   <= ptot_d;
            end
          end
        end
        BS_DIV5: begin
          q5_q    <= prod5[63:34];
          rsf_q   <= rsf_d;
          state_q <= BS_CUT;
        end
        BS_CUT: begin
          cut40_q <= cut40_d;
          state_q <= BS_MIN;
        end
        BS_MIN: begin
          cut_q   <= cut_d;
          state_q <= BS_WIN;
        end
        BS_WIN: begin
          win_q   <= win_d;
          state_q <= BS_PROD;
        end
        BS_PROD: begin
          prod_q  <= 54'(rsf_q) * 54'(win_q);
          state_q <= BS_RND;
        end
        BS_RND: begin
          sat_q   <= (p2 >= sgbp_pkg::SAT_LIMIT);
          x_q     <= p2[33:3];
          state_q <= BS_DIV;
        end
        BS_DIV: begin
          target_q <= target_d;
          state_q  <= BS_TOL;
        end
        BS_TOL: begin
          ld_q    <= ldp[31:8];
          ud_q    <= udp[33:8];
          state_q <= BS_OUT;
        end
        BS_OUT: begin
          if (out_free) begin
            ov_q     <= 1'b1;
            o_kind_q <= sgbp_pkg::KIND_BUDGET;
            o_off_q  <= '0;
            o_dur_q  <= '0;
            o_slot_q <= slot_q;
            o_win_q  <= win_q;
            o_tgt_q  <= target_q;
            o_min_q  <= minu;
            o_max_q  <= maxu;
            o_hw_q   <= hw_q;
            o_last_q <= 1'b1;
            ptot_q   <= '0;
            state_q  <= BS_IDLE;
          end
        end
        default: begin
          state_q <= BS_IDLE;
        end
      endcase
    end
  end

  assign results_o.valid            = ov_q;
  assign results_o.result_kind      = o_kind_q;
  assign results_o.offset_ms        = o_off_q;
  assign results_o.duration_ms      = o_dur_q;
  assign results_o.slot_ms          = o_slot_q;
  assign results_o.speech_window_ms = o_win_q;
  assign results_o.target_units     = o_tgt_q;
  assign results_o.min_units        = o_min_q;
  assign results_o.max_units        = o_max_q;
  assign results_o.has_words        = o_hw_q;
  assign results_o.last_result      = o_last_q;

  `SGBP_ASSERT_IMP(a_budget_order, clk_i, rst_ni, ov_q && (o_kind_q == sgbp_pkg::KIND_BUDGET), (o_min_q <= o_tgt_q) && (26'(o_tgt_q) <= o_max_q), "budget units out of order")
  `SGBP_ASSERT_IMP(a_no_pop_busy, clk_i, rst_ni, state_q != BS_IDLE, !pop_o, "pop while budget in progress")
  `SGBP_ASSERT_NXT(a_pause_loaded, clk_i, rst_ni, pop_o && (head_i.kind != sgbp_pkg::KIND_BUDGET), ov_q, "popped pause not presented")

endmodule
`default_nettype wire

@@ design/speech_gap_and_budget_planner_core.sv @@
// Top level of the speech gap and budget planner: config registers, front, queue, back.
//
//   port        dir   handshake      item
//   items_i     in    valid/ready    one word timestamp of a segment
//   results_o   out   valid/ready    pause or end-of-segment budget
//   cfg_*_i     in    write enable   config register write, no read-back
//
// A word item passes FS_WORD in the front, a last item also FS_TRAIL and FS_BUDGET.
// Pauses leave the back 1 per cycle while results_o is ready; a budget passes in the back
// through its multiply and reciprocal-divide steps.
// A 4-entry queue lets the front keep taking items while the back is busy.
// Reset clears segment state and restores config defaults; no clearing pass.
`default_nettype none
module speech_gap_and_budget_planner_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  sgbp_in_if.sink                              items_i,
  sgbp_out_if.source                           results_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [sgbp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sgbp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sgbp_pkg::cfg_t   cfg_q;
  logic             push, full, pop, empty;
  sgbp_pkg::entry_t push_data, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= sgbp_pkg::THR_RESET;
      cfg_q.rate      <= sgbp_pkg::RATE_RESET;
      cfg_q.safety    <= sgbp_pkg::SAFE_RESET;
      cfg_q.lower_tol <= sgbp_pkg::LOWER_RESET;
      cfg_q.upper_tol <= sgbp_pkg::UPPER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgbp_pkg::CFG_THRESHOLD: cfg_q.threshold <= cfg_data_i[10:0];
        sgbp_pkg::CFG_RATE:      cfg_q.rate      <= cfg_data_i[12:0];
        sgbp_pkg::CFG_SAFETY:    cfg_q.safety    <= cfg_data_i[8:0];
        sgbp_pkg::CFG_LOWER_TOL: cfg_q.lower_tol <= cfg_data_i[7:0];
        sgbp_pkg::CFG_UPPER_TOL: cfg_q.upper_tol <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  sgbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .items_i     (items_i),
    .cfg_i       (cfg_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  sgbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  sgbp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .head_i    (head),
    .empty_i   (empty),
    .pop_o     (pop),
    .results_o (results_o)
  );

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench of the speech gap and budget planner core.
module testbench;
  import sgbp_pkg::*;

  localparam longint CAP_MS          = 1500;
  localparam longint WINDOW_FLOOR_MS = 400;
  localparam longint RATE_MIN_Q8     = 26;
  localparam longint TARGET_SAT      = 64'd16777215;
  localparam longint MAXU_SAT        = 64'd67108863;
  localparam int     SETTLE_CYCLES   = 16;
  localparam int     TAIL_CYCLES     = 40;

  typedef struct packed {
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic        has_word;
    logic [31:0] ws;
    logic [31:0] we;
    logic        last;
  } word_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [32:0] offset;
    logic [10:0] dur;
    logic [31:0] slot;
    logic [31:0] window;
    logic [23:0] target;
    logic [23:0] min_u;
    logic [25:0] max_u;
    logic        has_words;
    logic        last;
  } plan_result_t;

  class gap_budget_model;
    logic [10:0] thr;
    logic [12:0] rate;
    logic [8:0]  safety;
    logic [7:0]  lower;
    logic [9:0]  upper;
    logic [31:0] prev_end;
    logic        have_prev;
    logic        saw_word;
    logic [31:0] pause_total;
    plan_result_t expected_results[$];
    int errors;

    function new();
      thr = 11'd300;
      rate = 13'd3584;
      safety = 9'd230;
      lower = 8'd51;
      upper = 10'd51;
      clear_segment();
      errors = 0;
    endfunction

    function void clear_segment();
      prev_end = '0;
      have_prev = 1'b0;
      saw_word = 1'b0;
      pause_total = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [12:0] v);
      case (idx)
        CFG_THRESHOLD: thr = v[10:0];
        CFG_RATE:      rate = v[12:0];
        CFG_SAFETY:    safety = v[8:0];
        CFG_LOWER_TOL: lower = v[7:0];
        CFG_UPPER_TOL: upper = v[9:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void add_pause(kind_e k, longint off, longint len);
      plan_result_t r;
      longint d;
      longint unsigned sum;
      d = (len > CAP_MS) ? CAP_MS : len;
      r = '0;
      r.kind = k;
      r.offset = off[32:0];
      r.dur = d[10:0];
      sum = longint'(pause_total) + d;
      pause_total = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
      expected_results.push_back(r);
    endfunction

    function void take_item(word_item_t it);
      longint ss, se, ws, we, prev, th, gap, slot, cut, win, tot;
      longint unsigned rate_e, prod, target, ld, ud, minu, maxu, wu;
      plan_result_t r;
      ss = it.seg_start;
      se = it.seg_end;
      ws = it.ws;
      we = it.we;
      th = thr;
      if (it.has_word) begin
        saw_word = 1'b1;
        if (we > ws) begin
          if (!have_prev) begin
            gap = ws - ss;
            if (gap < 0) gap = 0;
            if (gap >= th) add_pause(KIND_LEAD, 0, gap);
            have_prev = 1'b1;
            prev_end = it.we;
          end else begin
            prev = prev_end;
            gap = ws - prev;
            if (gap >= th) add_pause(KIND_INTERNAL, prev - ss, gap);
            if (we > prev) prev_end = it.we;
          end
        end
      end
      if (it.last) begin
        prev = prev_end;
        if (have_prev) begin
          gap = se - prev;
          if (gap < 0) gap = 0;
          if (gap >= th) add_pause(KIND_TRAIL, prev - ss, gap);
        end
        slot = se - ss;
        if (slot < 1) slot = 1;
        cut = slot * 40 / 100;
        tot = pause_total;
        if (tot < cut) cut = tot;
        win = slot - cut;
        if (win < WINDOW_FLOOR_MS) win = WINDOW_FLOOR_MS;
        wu = win;
        rate_e = rate;
        if (rate_e < RATE_MIN_Q8) rate_e = RATE_MIN_Q8;
        prod = rate_e * wu * longint'(safety);
        target = (prod + 64'd32768000) / 64'd65536000;
        if (target < 1) target = 1;
        if (target > TARGET_SAT) target = TARGET_SAT;
        ld = (target * longint'(lower) + 64'd128) >> 8;
        ud = (target * longint'(upper) + 64'd128) >> 8;
        minu = (ld >= target) ? 64'd1 : target - ld;
        maxu = target + ud;
        if (maxu > MAXU_SAT) maxu = MAXU_SAT;
        r = '0;
        r.kind = KIND_BUDGET;
        r.slot = slot[31:0];
        r.window = win[31:0];
        r.target = target[23:0];
        r.min_u = minu[23:0];
        r.max_u = maxu[25:0];
        r.has_words = saw_word;
        r.last = 1'b1;
        expected_results.push_back(r);
        clear_segment();
      end
    endfunction

    function void compare(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        if (errors < 40)
          $display("%0t %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(plan_result_t got);
      plan_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: kind %0d", $time, got.kind);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      compare("result_kind", exp_r.kind, got.kind);
      compare("offset_ms", exp_r.offset, got.offset);
      compare("duration_ms", exp_r.dur, got.dur);
      compare("slot_ms", exp_r.slot, got.slot);
      compare("speech_window_ms", exp_r.window, got.window);
      compare("target_units", exp_r.target, got.target);
      compare("min_units", exp_r.min_u, got.min_u);
      compare("max_units", exp_r.max_u, got.max_u);
      compare("has_words", exp_r.has_words, got.has_words);
      compare("last_result", exp_r.last, got.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  cfg_idx_e cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  bit calm;

  sgbp_in_if  items_if();
  sgbp_out_if results_if();

  gap_budget_model sb = new();

  speech_gap_and_budget_planner_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .items_i    (items_if),
    .results_o  (results_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1000000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays high across back-to-back items
  task automatic send_item(word_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    items_if.valid            <= 1'b1;
    items_if.segment_start_ms <= it.seg_start;
    items_if.segment_end_ms   <= it.seg_end;
    items_if.has_word         <= it.has_word;
    items_if.word_start_ms    <= it.ws;
    items_if.word_end_ms      <= it.we;
    items_if.last_word        <= it.last;
    do @(posedge clk_i); while (!items_if.ready);
    sb.take_item(it);
  endtask

  task automatic send_word(logic [31:0] ss, logic [31:0] se, logic hw,
                           logic [31:0] ws, logic [31:0] we, logic last);
    word_item_t it;
    it.seg_start = ss;
    it.seg_end = se;
    it.has_word = hw;
    it.ws = ws;
    it.we = we;
    it.last = last;
    send_item(it);
  endtask

  task automatic drain();
    items_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(logic [12:0] thr, logic [12:0] rate, logic [12:0] safe,
                            logic [12:0] lo, logic [12:0] up);
    cfg_idx_e regs [5];
    logic [12:0] vals [5];
    regs = '{CFG_THRESHOLD, CFG_RATE, CFG_SAFETY, CFG_LOWER_TOL, CFG_UPPER_TOL};
    vals = '{thr, rate, safe, lo, up};
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_segment();
    word_item_t it;
    int n, mode, pick;
    logic [31:0] t;
    n = $urandom_range(1, 6);
    mode = $urandom_range(0, 99);
    it.seg_start = $urandom_range(3000, 32'hFF000000);
    it.seg_end = it.seg_start + $urandom_range(0, n * 2500);
    if (mode < 5) begin
      it.seg_end = it.seg_start - $urandom_range(0, 2000);
    end else if (mode < 15) begin
      it.seg_start = $urandom();
      it.seg_end = $urandom();
    end
    t = it.seg_start + $urandom_range(0, 2500);
    if ($urandom_range(0, 9) == 0) t = it.seg_start - $urandom_range(1, 2000);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      it.has_word = 1'b1;
      it.ws = t;
      if (pick == 2) it.ws = t - $urandom_range(1, 3000);
      it.we = it.ws + $urandom_range(1, 900);
      if (pick == 0) it.we = it.ws - $urandom_range(0, 50);
      if (pick == 1) it.has_word = 1'b0;
      if (mode >= 15 && mode < 25) begin
        it.seg_start = $urandom();
        it.seg_end = $urandom();
        it.ws = $urandom();
        it.we = $urandom();
        it.has_word = $urandom_range(0, 1);
      end
      it.last = (k == n - 1);
      send_item(it);
      t = it.we + $urandom_range(0, 2500);
    end
  endtask

  initial begin : result_sink
    int stall;
    plan_result_t got;
    stall = 0;
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && results_if.valid && results_if.ready) begin
        got.kind      = kind_e'(results_if.result_kind);
        got.offset    = results_if.offset_ms;
        got.dur       = results_if.duration_ms;
        got.slot      = results_if.slot_ms;
        got.window    = results_if.speech_window_ms;
        got.target    = results_if.target_units;
        got.min_u     = results_if.min_units;
        got.max_u     = results_if.max_units;
        got.has_words = results_if.has_words;
        got.last      = results_if.last_result;
        sb.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_THRESHOLD;
    cfg_data_i = '0;
    calm = 1'b0;
    items_if.valid = 1'b0;
    items_if.segment_start_ms = '0;
    items_if.segment_end_ms = '0;
    items_if.has_word = 1'b0;
    items_if.word_start_ms = '0;
    items_if.word_end_ms = '0;
    items_if.last_word = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: lead, internal, invalid, overlap, wordless, trail
    send_word(1000, 5000, 1, 1500, 2000, 0);
    send_word(1000, 5000, 1, 2000, 2500, 0);
    send_word(1000, 5000, 1, 3000, 3200, 0);
    send_word(1000, 5000, 1, 3300, 3300, 0);
    send_word(1000, 5000, 1, 3100, 3150, 0);
    send_word(1000, 5000, 0, 32'hFFFFFFFF, 0, 0);
    send_word(1000, 5000, 1, 3500, 3600, 1);
    send_word(20, 20, 0, 0, 0, 1);
    send_word(10000, 9000, 1, 9500, 9800, 1);
    send_word(0, 32'hFFFFFFFF, 1, 0, 1, 0);
    send_word(0, 32'hFFFFFFFF, 1, 32'hFFFFFFF0, 32'hFFFFFFFF, 0);
    send_word(0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    send_word(0, 100000, 1, 500, 400, 1);
    send_word(0, 1000, 1, 600, 700, 1);
    send_word(0, 500, 1, 100, 200, 1);
    send_word(0, 50000, 1, 100, 200, 0);
    send_word(100000, 100000, 1, 5000, 5100, 0);
    send_word(0, 50000, 0, 0, 0, 1);

    // threshold zero reports zero-length gaps; rate below floor
    set_config(0, 0, 128, 0, 0);
    send_word(100, 200, 1, 100, 150, 0);
    send_word(100, 200, 1, 150, 200, 1);
    send_word(300, 300, 1, 200, 300, 1);
    repeat (7) random_segment();

    set_config(2047, 8191, 511, 255, 1023);
    send_word(0, 32'hFFFFFFFF, 1, 10, 20, 1);
    calm = 1'b1;
    repeat (7) random_segment();
    calm = 1'b0;

    set_config(80, 26, 256, 230, 512);
    repeat (7) random_segment();

    for (int p = 0; p < 3; p++) begin
      set_config($urandom_range(80, 2000), $urandom_range(26, 7680),
                 $urandom_range(128, 256), $urandom_range(0, 230), $urandom_range(0, 512));
      repeat (7) random_segment();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
